// File: design/call_return_shadow_stack_tracer_defines.svh
// assertion macros for the call/return shadow stack tracer
`ifndef CALL_RETURN_SHADOW_STACK_TRACER_DEFINES_SVH
`define CALL_RETURN_SHADOW_STACK_TRACER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define CRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("shadow stack check failed");

// next-cycle implication, checked out of reset
`define CRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("shadow stack check failed");

`else

`define CRS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CRS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/crsst_pkg.sv
// shared types and constants for the call/return shadow stack tracer
`timescale 1ns / 1ps

package crsst_pkg;

	// default number of frames held
	localparam int STACK_DEPTH_DEF = 64;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int CNT_W    = 7;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 144;

	// instruction decode constants
	localparam logic [6:0]  OPC_MASK_W = 7'h7f;
	localparam logic [6:0]  OPC_JAL    = 7'h6f;
	localparam logic [6:0]  OPC_JALR   = 7'h67;
	localparam logic [2:0]  F3_JALR    = 3'h0;
	localparam logic [4:0]  REG_ZERO   = 5'd0;
	localparam logic [4:0]  REG_RA     = 5'd1;
	localparam logic [4:0]  REG_T0     = 5'd5;
	localparam logic [11:0] IMM_ZERO   = 12'h000;
	localparam logic [31:0] INSN_LEN   = 32'd4;

	// event codes
	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_CALL      = 2'd1,
		EV_RET_MATCH = 2'd2,
		EV_RET_MISS  = 2'd3
	} event_kind_t;

	// one stack frame
	typedef struct packed {
		logic [ADDR_W-1:0] ret_addr;
		logic [ADDR_W-1:0] entry_addr;
	} frame_t;

	// shift control for the cell chain
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

	// decode result
	typedef struct packed {
		logic              is_call;
		logic              is_ret;
		logic [ADDR_W-1:0] fall_addr;
	} insn_class_t;

endpackage

// File: design/crsst_decode.sv
// link-register hint classification of one retired instruction
`timescale 1ns / 1ps

module crsst_decode (
	input  logic [crsst_pkg::ADDR_W-1:0] instr_pc,
	input  logic [crsst_pkg::ADDR_W-1:0] instr_word,
	input  logic [crsst_pkg::ADDR_W-1:0] next_pc,
	output crsst_pkg::insn_class_t       cls
);

	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [2:0]  f3;
	logic [11:0] imm;
	logic        is_jal;
	logic        is_jalr;
	logic        taken;
	logic [crsst_pkg::ADDR_W-1:0] fall;

	// instruction fields
	assign opc = instr_word[6:0] & crsst_pkg::OPC_MASK_W;
	assign rd  = instr_word[11:7];
	assign f3  = instr_word[14:12];
	assign rs1 = instr_word[19:15];
	assign imm = instr_word[31:20];

	// fall-through address and jump detection
	assign fall    = instr_pc + crsst_pkg::INSN_LEN;
	assign taken   = (next_pc != fall);
	assign is_jal  = (opc == crsst_pkg::OPC_JAL);
	assign is_jalr = (opc == crsst_pkg::OPC_JALR) && (f3 == crsst_pkg::F3_JALR);

	// call: link into ra or t0; return: jump through ra or t0 with no offset
	assign cls.is_call   = (is_jal || is_jalr) &&
		(rd == crsst_pkg::REG_RA || rd == crsst_pkg::REG_T0) && taken;
	assign cls.is_ret    = is_jalr && (rd == crsst_pkg::REG_ZERO) &&
		(rs1 == crsst_pkg::REG_RA || rs1 == crsst_pkg::REG_T0) &&
		(imm == crsst_pkg::IMM_ZERO) && taken;
	assign cls.fall_addr = fall;

endmodule

// File: design/crsst_cell.sv
// one frame cell of the shift-register stack
`timescale 1ns / 1ps

module crsst_cell (
	input  logic                  clk,
	input  crsst_pkg::shift_ctl_t ctl,
	input  crsst_pkg::frame_t     above_frame,
	input  crsst_pkg::frame_t     below_frame,
	output crsst_pkg::frame_t     frame_q
);

	// push takes the frame from the cell nearer the top, pop from the one below
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			frame_q <= above_frame;
		end else if (ctl.pop) begin
			frame_q <= below_frame;
		end
	end

endmodule

// File: design/call_return_shadow_stack_tracer.sv
// top level of the call/return shadow stack tracer
`timescale 1ns / 1ps
`include "call_return_shadow_stack_tracer_defines.svh"

// Takes one retired instruction word per input word (s_axis_tdata: instr_pc, instr_word,
// next_pc from bit 0 up) and gives exactly one result word per input word. Frames live
// in a chain of STACK_DEPTH cells with the top of stack in cell 0; a call shifts the
// chain down by one (the oldest frame falls off the end when full) and a return shifts
// it up by one frame per cycle while the output register is free, checking the top frame
// at each step. Calls, disabled tracing and other instructions give their result from
// idle; a matched return pops down to and including the matching frame, an unmatched
// return pops every frame on the stack. An input buffer takes the next word while a
// result waits on the output register. The user must write trace_enable through cfg_we /
// cfg_wdata only while the block is idle; the block itself does not enforce this.

module call_return_shadow_stack_tracer #(
	parameter int STACK_DEPTH = crsst_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	// input words
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// instr_pc [31:0], instr_word [63:32], next_pc [95:64]
	input  logic [crsst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// result words
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// event_pc [31:0], link_address [63:32], from_entry [95:64], to_entry [127:96],
	// to_entry_known [128], frames_unwound [135:129], depth_after [142:136],
	// overflow [143]
	output logic [crsst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// event_kind [1:0]
	output logic [1:0]                        m_axis_tuser
);

	localparam int AW = crsst_pkg::ADDR_W;
	localparam int OW = crsst_pkg::CNT_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] CNT_ONE    = CW'(1);
	localparam logic [CW-1:0] CNT_TWO    = CW'(2);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t st_q;

	// configuration and stack depth
	logic          trace_en_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] unw_q;

	// input buffer
	logic          inv_q;
	logic [AW-1:0] in_pc_q;
	logic [AW-1:0] in_word_q;
	logic [AW-1:0] in_next_q;

	// return being scanned
	logic [AW-1:0] tgt_q;
	logic [AW-1:0] epc_q;

	// output register
	logic                   ov_q;
	crsst_pkg::event_kind_t kind_q;
	logic [AW-1:0]          opc_q;
	logic [AW-1:0]          link_q;
	logic [AW-1:0]          from_q;
	logic [AW-1:0]          to_q;
	logic                   known_q;
	logic [OW-1:0]          unwind_q;
	logic [OW-1:0]          depth_q;
	logic                   ovf_q;

	crsst_pkg::insn_class_t cls;
	crsst_pkg::shift_ctl_t  ctl;
	crsst_pkg::frame_t      new_frame;
	crsst_pkg::frame_t      cell_q [STACK_DEPTH];

	logic out_free;
	logic start;
	logic in_acc;
	logic do_push;
	logic scan_step;
	logic scan_pop;
	logic top_hit;
	logic res_load;

	// classification of the buffered word
	crsst_decode u_decode (
		.instr_pc   (in_pc_q),
		.instr_word (in_word_q),
		.next_pc    (in_next_q),
		.cls        (cls)
	);

	// handshake and sequencing
	assign out_free      = !ov_q || m_axis_tready;
	assign start         = inv_q && (st_q == ST_IDLE) && out_free;
	assign s_axis_tready = !inv_q || start;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign do_push       = start && trace_en_q && cls.is_call;
	assign scan_step     = (st_q == ST_SCAN) && out_free;
	assign scan_pop      = scan_step && (cnt_q != '0);
	assign top_hit       = (cell_q[0].ret_addr == tgt_q);

	// a result word is loaded this cycle
	assign res_load = (start && !(trace_en_q && cls.is_ret)) ||
		(scan_step && ((cnt_q == '0) || top_hit));

	assign ctl.push = do_push;
	assign ctl.pop  = scan_pop;

	assign new_frame.ret_addr   = cls.fall_addr;
	assign new_frame.entry_addr = in_next_q;

	// chain of frame cells, cell 0 on top
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		crsst_pkg::frame_t above;
		crsst_pkg::frame_t below;

		if (i == 0) begin : g_top
			assign above = new_frame;
		end else begin : g_mid
			assign above = cell_q[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = cell_q[i];
		end else begin : g_up
			assign below = cell_q[i+1];
		end

		crsst_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.above_frame (above),
			.below_frame (below),
			.frame_q     (cell_q[i])
		);
	end

	// input buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
		end else if (in_acc) begin
			inv_q <= 1'b1;
		end else if (start) begin
			inv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_pc_q   <= s_axis_tdata[AW-1:0];
			in_word_q <= s_axis_tdata[2*AW-1:AW];
			in_next_q <= s_axis_tdata[3*AW-1:2*AW];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_en_q <= 1'b0;
		end else if (cfg_we) begin
			trace_en_q <= cfg_wdata;
		end
	end

	// sequencer state, depth and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			unw_q    <= '0;
			tgt_q    <= '0;
			epc_q    <= '0;
			ov_q     <= 1'b0;
			kind_q   <= crsst_pkg::EV_NONE;
			opc_q    <= '0;
			link_q   <= '0;
			from_q   <= '0;
			to_q     <= '0;
			known_q  <= 1'b0;
			unwind_q <= '0;
			depth_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			// result word held until taken
			ov_q <= res_load || (ov_q && !m_axis_tready);
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						if (trace_en_q && cls.is_ret) begin
							// return: scan from the top
							st_q  <= ST_SCAN;
							tgt_q <= in_next_q;
							epc_q <= in_pc_q;
							unw_q <= '0;
						end else if (trace_en_q && cls.is_call) begin
							// call: push, dropping the oldest frame when full
							kind_q   <= crsst_pkg::EV_CALL;
							opc_q    <= in_pc_q;
							link_q   <= cls.fall_addr;
							from_q   <= '0;
							to_q     <= in_next_q;
							known_q  <= 1'b1;
							unwind_q <= '0;
							ovf_q    <= (cnt_q == DEPTH_FULL);
							if (cnt_q == DEPTH_FULL) begin
								depth_q <= OW'(cnt_q);
							end else begin
								cnt_q   <= cnt_q + CNT_ONE;
								depth_q <= OW'(cnt_q + CNT_ONE);
							end
						end else begin
							// disabled or not a call or return
							kind_q   <= crsst_pkg::EV_NONE;
							opc_q    <= '0;
							link_q   <= '0;
							from_q   <= '0;
							to_q     <= '0;
							known_q  <= 1'b0;
							unwind_q <= '0;
							depth_q  <= OW'(cnt_q);
							ovf_q    <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						if (cnt_q == '0) begin
							// stack emptied with no match
							st_q     <= ST_IDLE;
							kind_q   <= crsst_pkg::EV_RET_MISS;
							opc_q    <= epc_q;
							link_q   <= tgt_q;
							from_q   <= '0;
							to_q     <= '0;
							known_q  <= 1'b0;
							unwind_q <= OW'(unw_q);
							depth_q  <= '0;
							ovf_q    <= 1'b0;
						end else if (top_hit) begin
							// matching frame on top: pop it and finish
							st_q     <= ST_IDLE;
							cnt_q    <= cnt_q - CNT_ONE;
							kind_q   <= crsst_pkg::EV_RET_MATCH;
							opc_q    <= epc_q;
							link_q   <= tgt_q;
							from_q   <= cell_q[0].entry_addr;
							known_q  <= (cnt_q >= CNT_TWO);
							to_q     <= (cnt_q >= CNT_TWO) ? cell_q[1].entry_addr : '0;
							unwind_q <= OW'(unw_q + CNT_ONE);
							depth_q  <= OW'(cnt_q - CNT_ONE);
							ovf_q    <= 1'b0;
						end else begin
							// pop a frame that does not match
							cnt_q <= cnt_q - CNT_ONE;
							unw_q <= unw_q + CNT_ONE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word
	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tdata  = {ovf_q, depth_q, unwind_q, known_q, to_q, from_q, link_q, opc_q};

	// checks
	`CRS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= DEPTH_FULL)
	`CRS_ASSERT_NXT(a_scan_pops, clk, arst_n, scan_pop, cnt_q == $past(cnt_q) - CNT_ONE)
	`CRS_ASSERT_NXT(a_full_push, clk, arst_n, do_push && cnt_q == DEPTH_FULL, ovf_q && ov_q)
	`CRS_ASSERT_IMP(a_no_push_scan, clk, arst_n, st_q == ST_SCAN, !do_push && !inv_q || !start)

endmodule
